/* hw/rtl/prrs_pkg.sv */
// Shared types, codes and default sizes for the priority round-robin scheduler.
package prrs_pkg;

  // Default sizing
  localparam int unsigned TopLevelDefault   = 5;
  localparam int unsigned QueueDepthDefault = 64;

  // Fixed field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned IdW      = 6;
  localparam int unsigned PrioW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned QuantumW = 16;

  localparam logic [QuantumW-1:0] QuantumReset = 16'd4;

  // Event codes
  localparam logic [CmdW-1:0] CMD_ADD  = 2'd0;
  localparam logic [CmdW-1:0] CMD_TICK = 2'd1;
  localparam logic [CmdW-1:0] CMD_EXIT = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_ADD_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STAT_EXIT_IDLE = 2'd2;

  typedef logic [IdW-1:0] thread_id_t;

endpackage

/* hw/rtl/prrs_queue_ram.sv */
// Ready-queue storage: one write port, one read port, registered read-first data.
module prrs_queue_ram #(
  parameter int unsigned Depth = prrs_pkg::QueueDepthDefault * (prrs_pkg::TopLevelDefault + 1),
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [AddrW-1:0]       wr_addr_i,
  input  prrs_pkg::thread_id_t   wr_data_i,
  input  logic                   rd_en_i,
  input  logic [AddrW-1:0]       rd_addr_i,
  output prrs_pkg::thread_id_t   rd_data_o
);
  import prrs_pkg::*;

  thread_id_t mem [Depth];
  thread_id_t rd_data_q;

  // Read returns the old entry when the same address is written in that cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/priority_round_robin_scheduler_core.sv */
// Top level of the priority round-robin thread scheduler.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per request:
//   cmd_i = add, tick or exit, with thread_id_i and priority_req_i for adds.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   request: running thread, switched flag and status.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_wdata_i) writes the
//   quantum; write it only while no request is in flight.
// Timing:
//   A request is decided in its accept cycle, where the ready-queue RAM is
//   read and written; the result register loads on the next edge once the
//   RAM read data returns, and out_valid_o rises with it. in_stall_o is high
//   while the read data returns, so a new request is taken only after that load.
// Reset:
//   All queues empty, nothing running, tick counter 0, quantum 4. The RAM
//   is not cleared; only occupied entries are ever read.
// Stall:
//   While a result waits under out_stall_i, in_stall_o stays high, so at
//   most one request is in flight.
module priority_round_robin_scheduler_core #(
  parameter int unsigned TopLevel   = prrs_pkg::TopLevelDefault,
  parameter int unsigned QueueDepth = prrs_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Config write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [prrs_pkg::QuantumW-1:0]  cfg_wdata_i,
  // Event requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [prrs_pkg::CmdW-1:0]      cmd_i,
  input  logic [prrs_pkg::IdW-1:0]       thread_id_i,
  input  logic [prrs_pkg::PrioW-1:0]     priority_req_i,
  // Results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           running_valid_o,
  output logic [prrs_pkg::IdW-1:0]       running_id_o,
  output logic [prrs_pkg::PrioW-1:0]     running_priority_o,
  output logic                           switched_o,
  output logic [prrs_pkg::StatusW-1:0]   status_o
);
  import prrs_pkg::*;

  localparam int unsigned Levels  = TopLevel + 1;
  localparam int unsigned LvlW    = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned PtrW    = $clog2(QueueDepth);
  localparam int unsigned CntW    = $clog2(QueueDepth + 1);
  localparam int unsigned RamSize = Levels * QueueDepth;
  localparam int unsigned AddrW   = $clog2(RamSize);
  localparam int unsigned SatW    = (LvlW > PrioW) ? LvlW + 1 : PrioW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DONE = 1'b1;

  // ---------------------------------------------------------------------------
  // State
  logic                state_q;
  logic [QuantumW-1:0] quantum_q;
  logic [PtrW-1:0]     head_q [Levels];
  logic [PtrW-1:0]     tail_q [Levels];
  logic [CntW-1:0]     cnt_q  [Levels];
  logic [PtrW-1:0]     head_d [Levels];
  logic [PtrW-1:0]     tail_d [Levels];
  logic [CntW-1:0]     cnt_d  [Levels];
  logic                cur_valid_q, cur_valid_d;
  thread_id_t          cur_id_q, cur_id_d;
  logic [LvlW-1:0]     cur_lvl_q, cur_lvl_d;
  logic [QuantumW-1:0] elapsed_q, elapsed_d;
  logic                deq_pend_q;
  logic                switched_q, switched_d;
  logic [StatusW-1:0]  status_q, status_d;

  // Result register
  logic                out_valid_q;
  logic                out_run_valid_q;
  thread_id_t          out_id_q;
  logic [LvlW-1:0]     out_lvl_q;
  logic                out_switched_q;
  logic [StatusW-1:0]  out_status_q;

  logic accept;
  assign in_stall_o  = (state_q == ST_DONE) | (out_valid_q & out_stall_i);
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Level saturation and best-level search
  logic [SatW-1:0] prio_ext;
  logic [LvlW-1:0] req_lvl;
  logic            best_found;
  logic [LvlW-1:0] best_lvl;
  logic [Levels-1:0] nonempty;

  assign prio_ext = SatW'(priority_req_i);
  assign req_lvl  = (prio_ext > SatW'(TopLevel)) ? LvlW'(TopLevel) : LvlW'(priority_req_i);

  always_comb begin
    best_found = 1'b0;
    best_lvl   = '0;
    for (int l = 0; l < Levels; l++) begin
      nonempty[l] = (cnt_q[l] != '0);
      if (nonempty[l]) begin
        best_found = 1'b1;
        best_lvl   = LvlW'(l);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Event decision
  logic            enq, deq;
  logic [LvlW-1:0] enq_lvl;
  thread_id_t      enq_id;
  logic [QuantumW-1:0] elapsed_inc;
  logic            req_full, cur_full;

  assign elapsed_inc = elapsed_q + QuantumW'(1);
  assign req_full    = (cnt_q[req_lvl]   == CntW'(QueueDepth));
  assign cur_full    = (cnt_q[cur_lvl_q] == CntW'(QueueDepth));

  always_comb begin
    enq         = 1'b0;
    deq         = 1'b0;
    enq_lvl     = req_lvl;
    enq_id      = thread_id_i;
    cur_valid_d = cur_valid_q;
    cur_id_d    = cur_id_q;
    cur_lvl_d   = cur_lvl_q;
    elapsed_d   = elapsed_q;
    switched_d  = 1'b0;
    status_d    = STAT_OK;
    if (accept) begin
      unique case (cmd_i)
        CMD_ADD: begin
          if (!cur_valid_q) begin
            cur_valid_d = 1'b1;
            cur_id_d    = thread_id_i;
            cur_lvl_d   = req_lvl;
            elapsed_d   = '0;
            switched_d  = 1'b1;
          end else if (req_full) begin
            status_d = STAT_ADD_FULL;
          end else begin
            enq = 1'b1;
          end
        end
        CMD_TICK: begin
          if (cur_valid_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc == quantum_q) begin
              elapsed_d = '0;
              if (best_found && (best_lvl >= cur_lvl_q) &&
                  ((best_lvl == cur_lvl_q) || !cur_full)) begin
                deq        = 1'b1;
                enq        = 1'b1;
                enq_lvl    = cur_lvl_q;
                enq_id     = cur_id_q;
                cur_lvl_d  = best_lvl;
                switched_d = 1'b1;
              end
            end
          end
        end
        CMD_EXIT: begin
          if (!cur_valid_q) begin
            status_d = STAT_EXIT_IDLE;
          end else begin
            if (best_found) begin
              deq       = 1'b1;
              cur_lvl_d = best_lvl;
            end else begin
              cur_valid_d = 1'b0;
              cur_id_d    = '0;
              cur_lvl_d   = '0;
            end
            elapsed_d  = '0;
            switched_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pointer and count updates per level
  always_comb begin
    for (int l = 0; l < Levels; l++) begin
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      cnt_d[l]  = cnt_q[l];
      if (enq && (enq_lvl == LvlW'(l))) begin
        tail_d[l] = (tail_q[l] == PtrW'(QueueDepth - 1)) ? '0 : tail_q[l] + PtrW'(1);
      end
      if (deq && (best_lvl == LvlW'(l))) begin
        head_d[l] = (head_q[l] == PtrW'(QueueDepth - 1)) ? '0 : head_q[l] + PtrW'(1);
      end
      if ((enq && (enq_lvl == LvlW'(l))) && !(deq && (best_lvl == LvlW'(l)))) begin
        cnt_d[l] = cnt_q[l] + CntW'(1);
      end else if (!(enq && (enq_lvl == LvlW'(l))) && (deq && (best_lvl == LvlW'(l)))) begin
        cnt_d[l] = cnt_q[l] - CntW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Queue RAM: enqueue writes at the tail, dequeue reads the head
  logic [AddrW-1:0] wr_addr, rd_addr;
  thread_id_t       rd_data;

  assign wr_addr = AddrW'(enq_lvl) * AddrW'(QueueDepth) + AddrW'(tail_q[enq_lvl]);
  assign rd_addr = AddrW'(best_lvl) * AddrW'(QueueDepth) + AddrW'(head_q[best_lvl]);

  prrs_queue_ram #(
    .Depth (RamSize),
    .AddrW (AddrW)
  ) u_queue_ram (
    .clk_i     (clk_i),
    .wr_en_i   (enq),
    .wr_addr_i (wr_addr),
    .wr_data_i (enq_id),
    .rd_en_i   (deq),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and scheduler registers
  thread_id_t id_final;
  assign id_final = deq_pend_q ? rd_data : cur_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quantum_q   <= QuantumReset;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      cur_lvl_q   <= '0;
      elapsed_q   <= '0;
      deq_pend_q  <= 1'b0;
      switched_q  <= 1'b0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
      for (int l = 0; l < Levels; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_wdata_i;
      end
      for (int l = 0; l < Levels; l++) begin
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q     <= ST_DONE;
            cur_valid_q <= cur_valid_d;
            cur_id_q    <= cur_id_d;
            cur_lvl_q   <= cur_lvl_d;
            elapsed_q   <= elapsed_d;
            deq_pend_q  <= deq;
            switched_q  <= switched_d;
            status_q    <= status_d;
          end
        end
        ST_DONE: begin
          state_q     <= ST_IDLE;
          cur_id_q    <= id_final;
          deq_pend_q  <= 1'b0;
          out_valid_q <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      out_run_valid_q <= cur_valid_q;
      out_id_q        <= cur_valid_q ? id_final : '0;
      out_lvl_q       <= cur_valid_q ? cur_lvl_q : '0;
      out_switched_q  <= switched_q;
      out_status_q    <= status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign running_valid_o    = out_run_valid_q;
  assign running_id_o       = out_id_q;
  assign running_priority_o = PrioW'(out_lvl_q);
  assign switched_o         = out_switched_q;
  assign status_o           = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DONE))
    else $error("request accepted without entering result cycle");

  a_done_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !out_valid_q)
    else $error("result register still occupied when result is ready");

  a_dequeue_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && deq) |-> best_found)
    else $error("dequeue issued with every queue empty");

  a_exit_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EXIT_IDLE)) |-> (!running_valid_o && !switched_o))
    else $error("exit while idle reported a running thread");

endmodule
